>>> rtl/core/group_value_delta_cache_top_assert.svh
// assertion macros used by the cache top module
`ifndef GROUP_VALUE_DELTA_CACHE_TOP_ASSERT_SVH
`define GROUP_VALUE_DELTA_CACHE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GVDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache assertion failed (same cycle)");

// consequent checked in the cycle after the antecedent
`define GVDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache assertion failed (next cycle)");

`endif

>>> rtl/core/gvdc_pkg.sv
// types, constants and codes shared by the group value delta cache
package gvdc_pkg;

	localparam int unsigned POSITION_MODULUS = 100000;
	localparam int unsigned ADDR_BITS        = 16;
	localparam int unsigned MAX_VALUE_BYTES  = 8;

	localparam int unsigned TABLE_DEPTH   = 1 << ADDR_BITS;
	localparam int unsigned POS_W         = $clog2(POSITION_MODULUS);
	localparam int unsigned HALF_MODULUS  = POSITION_MODULUS / 2;
	localparam int unsigned VALUE_W       = 64;
	localparam int unsigned LEN_W         = 4;
	localparam int unsigned POS_FIELD_W   = 17;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_GET   = 2'd1,
		REQ_DELTA = 2'd2,
		REQ_CLEAR = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_SWEEP   = 2'd0,
		ST_IDLE    = 2'd1,
		ST_RESOLVE = 2'd2
	} state_t;

	typedef struct packed {
		req_kind_t                 req_type;
		logic [15:0]               group_addr;
		logic [VALUE_W-1:0]        value;
		logic [LEN_W-1:0]          value_len;
		logic [31:0]               now_sec;
		logic signed [31:0]        max_age;
		logic [POS_FIELD_W-1:0]    seen_pos;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic [VALUE_W-1:0]        read_value;
		logic [LEN_W-1:0]          read_len;
		logic [POS_FIELD_W-1:0]    position;
	} rsp_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   length;
		logic [31:0]        stamp;
		pos_t               pos;
	} entry_t;

	// request after the issue stage
	typedef struct packed {
		req_kind_t          kind;
		addr_t              addr;
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   len;
		logic [31:0]        now_sec;
		logic [31:0]        max_age;
		logic               new_client;
		pos_t               since_red;
		pos_t               gap;
		logic               refresh;
	} stage_t;

	// resolve unit decisions back to the controller
	typedef struct packed {
		logic   wr_en;
		entry_t wr_entry;
		pos_t   next_pos;
		rsp_t   rsp;
	} resolve_t;

endpackage

>>> rtl/core/gvdc_ram.sv
// generic simple dual port ram with registered read
module gvdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/gvdc_resolve.sv
// hit evaluation, entry update and position advance for one request
module gvdc_resolve (
	input  gvdc_pkg::stage_t   req,
	input  gvdc_pkg::entry_t   entry,
	input  gvdc_pkg::pos_t     cur_pos,
	output gvdc_pkg::resolve_t res
);
	import gvdc_pkg::*;

	logic        age_ok;
	logic [31:0] age_diff;
	logic [31:0] e_w;
	pos_t        e_dist;
	logic        delta_ok;
	logic        hit;
	logic [31:0] pos_w;

	always_comb begin
		age_diff = req.now_sec - entry.stamp;
		// negative max age turns the age filter off
		age_ok = req.max_age[31] || (age_diff < req.max_age);

		if (entry.pos >= req.since_red) begin
			e_w = 32'(entry.pos) - 32'(req.since_red);
		end else begin
			e_w = 32'(entry.pos) + 32'(POSITION_MODULUS) - 32'(req.since_red);
		end
		e_dist = e_w[POS_W-1:0];
		delta_ok = req.refresh ||
			((e_dist <= req.gap) && !(req.new_client && (e_dist == '0)));

		case (req.kind)
			REQ_GET:   hit = entry.valid && age_ok;
			REQ_DELTA: hit = entry.valid && age_ok && delta_ok;
			default:   hit = 1'b0;
		endcase

		case (req.kind)
			REQ_PUSH:  res.next_pos = (32'(cur_pos) == 32'(POSITION_MODULUS - 1)) ?
				'0 : cur_pos + 1'b1;
			REQ_CLEAR: res.next_pos = '0;
			default:   res.next_pos = cur_pos;
		endcase

		res.wr_en          = (req.kind == REQ_PUSH);
		res.wr_entry.valid  = 1'b1;
		res.wr_entry.value  = req.value;
		res.wr_entry.length = req.len;
		res.wr_entry.stamp  = req.now_sec;
		res.wr_entry.pos    = cur_pos;

		pos_w = 32'(res.next_pos);
		res.rsp.hit        = hit;
		res.rsp.read_value = hit ? entry.value : '0;
		res.rsp.read_len   = hit ? entry.length : '0;
		res.rsp.position   = pos_w[POS_FIELD_W-1:0];
	end

endmodule

>>> rtl/core/group_value_delta_cache_top.sv
// group value delta cache: last-value table with age and delta queries
// the request transfer loads the request register and the table read, the result register loads
// once the output is free; a new request is taken only after that, as the table is read then written
// clear: the result register loads, then a sweep pass over every table address invalidates the table
// reset: the same invalidation pass runs before the first request is taken
// the position counter resets to zero; entry payloads are not reset
module group_value_delta_cache_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  gvdc_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output gvdc_pkg::rsp_t   rsp
);
	import gvdc_pkg::*;

	state_t   state_q;
	state_t   state_nxt;
	addr_t    sweep_cnt_q;
	pos_t     wp_q;
	stage_t   req_s1;
	stage_t   issue;
	resolve_t res;
	entry_t   rd_entry;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	logic     accept;
	logic     out_free;
	logic     fire;
	logic     ram_we;
	addr_t    ram_waddr;
	entry_t   ram_wdata;
	logic [$bits(entry_t)-1:0] ram_rdata;

	logic [31:0]    since_w;
	logic [31:0]    d_w;
	logic [LEN_W-1:0] len_sat;

	assign accept   = req_valid && (state_q == ST_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fire     = (state_q == ST_RESOLVE) && out_free;
	assign rd_entry = entry_t'(ram_rdata);

	// issue stage: reduce since position, distance to write position, length saturation, byte masking, refresh flag
	always_comb begin
		since_w = 32'(req.seen_pos);
		if (since_w >= 32'(POSITION_MODULUS)) begin
			since_w = since_w - 32'(POSITION_MODULUS);
		end
		if (32'(wp_q) >= since_w) begin
			d_w = 32'(wp_q) - since_w;
		end else begin
			d_w = 32'(wp_q) + 32'(POSITION_MODULUS) - since_w;
		end
		len_sat = (32'(req.value_len) > 32'(MAX_VALUE_BYTES)) ?
			LEN_W'(MAX_VALUE_BYTES) : req.value_len;

		issue.kind       = req.req_type;
		issue.addr       = req.group_addr[ADDR_BITS-1:0];
		issue.len        = len_sat;
		issue.now_sec    = req.now_sec;
		issue.max_age    = req.max_age;
		issue.new_client = (req.seen_pos != '0);
		issue.since_red  = since_w[POS_W-1:0];
		issue.gap        = d_w[POS_W-1:0];
		issue.refresh    = issue.new_client && (d_w >= 32'(HALF_MODULUS));
		for (int i = 0; i < VALUE_W / 8; i++) begin
			issue.value[i*8 +: 8] = (32'(i) < 32'(len_sat)) ? req.value[i*8 +: 8] : 8'h00;
		end
	end

	gvdc_resolve u_resolve (
		.req     (req_s1),
		.entry   (rd_entry),
		.cur_pos (wp_q),
		.res     (res)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = req_s1.addr;
		ram_wdata = res.wr_entry;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = '0;
		end else if (fire) begin
			ram_we = res.wr_en;
		end
	end

	gvdc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (issue.addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_cnt_q == '1) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_nxt = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (out_free) begin
					state_nxt = (req_s1.kind == REQ_CLEAR) ? ST_SWEEP : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_cnt_q <= '0;
			wp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
			if (fire) begin
				wp_q        <= res.next_pos;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= issue;
		end
		if (fire) begin
			rsp_q <= res.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "group_value_delta_cache_top_assert.svh"

	`GVDC_ASSERT_NEXT(a_accept_resolves, clk, arst_n, accept, state_q == ST_RESOLVE)
	`GVDC_ASSERT_NOW(a_no_write_on_read, clk, arst_n, ram_we, !accept)
	`GVDC_ASSERT_NOW(a_no_hit_on_update, clk, arst_n,
		fire && (req_s1.kind == REQ_PUSH || req_s1.kind == REQ_CLEAR), !res.rsp.hit)
	`GVDC_ASSERT_NEXT(a_sweep_ends_idle, clk, arst_n,
		state_q == ST_SWEEP && sweep_cnt_q == '1, state_q == ST_IDLE && !req_stall)

endmodule

>>> tb/testbench.sv
// self-checking testbench for the group value delta cache
`timescale 1ns / 100ps

module testbench;
	import gvdc_pkg::*;

	localparam int unsigned STALL_LIMIT = 300000;
	localparam int unsigned RANDOM_ITEMS = 850;

	typedef struct {
		logic [63:0] val;
		logic [3:0]  len;
		logic [31:0] stamp;
		int unsigned pos;
	} cache_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow of the table and the write position
	cache_slot_t cache_tbl [int unsigned];
	int unsigned write_pos = 0;

	// directed rows, typed expectation where it is obvious
	req_t plan_req [$];
	bit   plan_typed [$];
	rsp_t plan_rsp [$];

	rsp_t expected_rsp [$];

	logic [15:0] hot_addr [12];
	logic [31:0] clock_sec = 32'd1000;
	int unsigned rand_issued = 0;
	int unsigned clears_left = 4;
	bit src_done = 1'b0;
	bit calm;

	bit   cur_typed;
	rsp_t cur_rsp;
	req_t nxt_req;
	bit   nxt_typed;
	rsp_t nxt_rsp;
	rsp_t pred_rsp;
	rsp_t want_rsp;

	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_push = 0, n_get = 0, n_delta = 0, n_clear = 0, n_hit = 0;

	group_value_delta_cache_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// no idling on either side for a stretch of the random part
	assign calm = rand_issued >= 150 && rand_issued < 300;

	function automatic logic [63:0] byte_mask(int unsigned n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic bit young_enough(cache_slot_t sl, logic [31:0] now,
			logic signed [31:0] age);
		logic [31:0] diff;
		if (age < 0)
			return 1'b1;
		diff = now - sl.stamp;
		return diff < $unsigned(age);
	endfunction

	function automatic rsp_t predict_cache(req_t r);
		rsp_t res;
		cache_slot_t sl;
		int unsigned key, ln, s, d, e;
		bit present, refresh;
		res = '0;
		key = 32'(r.group_addr[ADDR_BITS-1:0]);
		present = cache_tbl.exists(key);
		if (present)
			sl = cache_tbl[key];
		case (r.req_type)
			REQ_PUSH: begin
				ln = (32'(r.value_len) > MAX_VALUE_BYTES) ? MAX_VALUE_BYTES :
					32'(r.value_len);
				sl.len = 4'(ln);
				sl.val = r.value & byte_mask(ln);
				sl.stamp = r.now_sec;
				sl.pos = write_pos;
				cache_tbl[key] = sl;
				write_pos = (write_pos + 1) % POSITION_MODULUS;
			end
			REQ_GET: begin
				res.hit = present && young_enough(sl, r.now_sec, r.max_age);
			end
			REQ_DELTA: begin
				// since position is reduced first, the new-client test uses it raw
				s = 32'(r.seen_pos) % POSITION_MODULUS;
				d = (write_pos + POSITION_MODULUS - s) % POSITION_MODULUS;
				refresh = r.seen_pos != 0 && d >= HALF_MODULUS;
				if (present && young_enough(sl, r.now_sec, r.max_age)) begin
					e = (sl.pos + POSITION_MODULUS - s) % POSITION_MODULUS;
					res.hit = refresh || (e <= d && !(r.seen_pos != 0 && e == 0));
				end
			end
			default: begin
				cache_tbl.delete();
				write_pos = 0;
			end
		endcase
		if (res.hit) begin
			res.read_value = sl.val;
			res.read_len = sl.len;
		end
		res.position = 17'(write_pos);
		return res;
	endfunction

	function automatic req_t mk_req(req_kind_t k, logic [15:0] a, logic [63:0] v,
			logic [3:0] n, logic [31:0] t, logic signed [31:0] age, logic [16:0] sp);
		req_t r;
		r.req_type = k;
		r.group_addr = a;
		r.value = v;
		r.value_len = n;
		r.now_sec = t;
		r.max_age = age;
		r.seen_pos = sp;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(bit h, logic [63:0] v, logic [3:0] n, logic [16:0] p);
		rsp_t r;
		r.hit = h;
		r.read_value = v;
		r.read_len = n;
		r.position = p;
		return r;
	endfunction

	task automatic add_row(req_t r, bit typed, rsp_t e = '0);
		plan_req.push_back(r);
		plan_typed.push_back(typed);
		plan_rsp.push_back(e);
	endtask

	function automatic req_t random_req();
		req_t r;
		int unsigned pick, k;
		r.value = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			r.value_len = 4'($urandom_range(9, 15));
		else
			r.value_len = 4'($urandom_range(0, 8));
		clock_sec = clock_sec + $urandom_range(0, 3);
		r.now_sec = ($urandom_range(0, 19) == 0) ? $urandom : clock_sec;
		if ($urandom_range(0, 9) < 7)
			r.group_addr = hot_addr[$urandom_range(0, 11)];
		else
			r.group_addr = 16'($urandom);
		k = $urandom_range(0, 9);
		if (k < 3)
			r.max_age = (k == 0) ? -32'sd1 : $signed($urandom | 32'h8000_0000);
		else if (k == 3)
			r.max_age = 0;
		else if (k < 8)
			r.max_age = $urandom_range(1, 50);
		else
			r.max_age = $signed($urandom & 32'h7FFF_FFFF);
		k = $urandom_range(0, 9);
		if (k < 2)
			r.seen_pos = '0;
		else if (k < 6)
			r.seen_pos = 17'((write_pos + POSITION_MODULUS - $urandom_range(0, 20))
				% POSITION_MODULUS);
		else if (k < 8)
			r.seen_pos = 17'((write_pos + $urandom_range(1, 20)) % POSITION_MODULUS);
		else if (k == 8)
			// around the half-modulus boundary of the refresh rule
			r.seen_pos = 17'((write_pos + 2 * POSITION_MODULUS - HALF_MODULUS
				+ $urandom_range(0, 4) - 2) % POSITION_MODULUS);
		else
			r.seen_pos = 17'($urandom_range(0, 131071));
		pick = $urandom_range(0, 99);
		if (pick < 2 && clears_left > 0) begin
			r.req_type = REQ_CLEAR;
			clears_left--;
		end else if (pick < 37) begin
			r.req_type = REQ_PUSH;
		end else if (pick < 67) begin
			r.req_type = REQ_GET;
		end else begin
			r.req_type = REQ_DELTA;
		end
		return r;
	endfunction

	function automatic bit next_item(output req_t r, output bit typed, output rsp_t e);
		typed = 1'b0;
		e = '0;
		if (plan_req.size() != 0) begin
			r = plan_req.pop_front();
			typed = plan_typed.pop_front();
			e = plan_rsp.pop_front();
			return 1'b1;
		end
		if (rand_issued >= RANDOM_ITEMS)
			return 1'b0;
		rand_issued++;
		r = random_req();
		return 1'b1;
	endfunction

	task automatic check_rsp(rsp_t got, rsp_t want);
		if (got.hit !== want.hit) begin
			fail_count++;
			$error("hit: expected %0d, actual %0d", want.hit, got.hit);
		end
		if (got.read_value !== want.read_value) begin
			fail_count++;
			$error("read_value: expected %h, actual %h", want.read_value, got.read_value);
		end
		if (got.read_len !== want.read_len) begin
			fail_count++;
			$error("read_len: expected %0d, actual %0d", want.read_len, got.read_len);
		end
		if (got.position !== want.position) begin
			fail_count++;
			$error("position: expected %0d, actual %0d", want.position, got.position);
		end
	endtask

	// request side: a stalled transfer holds valid and payload
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				pred_rsp = predict_cache(req);
				case (req.req_type)
					REQ_PUSH: n_push++;
					REQ_GET: n_get++;
					REQ_DELTA: n_delta++;
					default: n_clear++;
				endcase
				if (pred_rsp.hit)
					n_hit++;
				expected_rsp.push_back(cur_typed ? cur_rsp : pred_rsp);
			end
			if (!req_valid || !req_stall) begin
				if (!calm && $urandom_range(0, 99) < 25) begin
					req_valid <= 1'b0;
				end else if (next_item(nxt_req, nxt_typed, nxt_rsp)) begin
					req <= nxt_req;
					cur_typed = nxt_typed;
					cur_rsp = nxt_rsp;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
					src_done = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_stall <= !calm && $urandom_range(0, 99) < 25;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				fail_count++;
				$error("result transfer with no request outstanding");
			end else begin
				want_rsp = expected_rsp.pop_front();
				check_rsp(rsp, want_rsp);
			end
		end
	end

	// watchdog: the clearing pass is the longest legal gap
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		hot_addr[0] = 16'h0000;
		hot_addr[1] = 16'hFFFF;
		for (int i = 2; i < 12; i++)
			hot_addr[i] = 16'($urandom);

		add_row(mk_req(REQ_GET, 16'h0000, '0, 4'd0, 32'd0, -32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd0));
		add_row(mk_req(REQ_DELTA, 16'hFFFF, '0, 4'd0, 32'd0, -32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd0));
		add_row(mk_req(REQ_PUSH, 16'h0000, '1, 4'd8, 32'd100, 32'sd0, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd1));
		// length above the limit saturates
		add_row(mk_req(REQ_PUSH, 16'hFFFF, '1, 4'd15, 32'hFFFF_FFFF, 32'sd0, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd2));
		add_row(mk_req(REQ_PUSH, 16'h0001, '1, 4'd3, 32'd100, 32'sd0, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd3));
		add_row(mk_req(REQ_PUSH, 16'h0002, '1, 4'd0, 32'd100, 32'sd0, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd4));
		add_row(mk_req(REQ_GET, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b1, '1, 4'd8, 17'd4));
		// zero max age never passes
		add_row(mk_req(REQ_GET, 16'h0000, '0, 4'd0, 32'd100, 32'sd0, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd4));
		// bytes beyond the length come back cleared
		add_row(mk_req(REQ_GET, 16'h0001, '0, 4'd0, 32'd100, 32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b1, 64'hFF_FFFF, 4'd3, 17'd4));
		// age across the 2^32 wrap of the seconds counter
		add_row(mk_req(REQ_GET, 16'hFFFF, '0, 4'd0, 32'd0, 32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd4));
		add_row(mk_req(REQ_GET, 16'hFFFF, '0, 4'd0, 32'd0, 32'sd2, 17'd0), 1'b1,
			mk_rsp(1'b1, '1, 4'd8, 17'd4));
		add_row(mk_req(REQ_GET, 16'h0002, '0, 4'd0, 32'd100, 32'sh7FFF_FFFF, 17'd0), 1'b1,
			mk_rsp(1'b1, '0, 4'd0, 17'd4));
		add_row(mk_req(REQ_GET, 16'h0000, '0, 4'd0, 32'd50, 32'sh7FFF_FFFF, 17'd0), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd0), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd1), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0001, '0, 4'd0, 32'd100, -32'sd1, 17'd4), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0001, '0, 4'd0, 32'd100, -32'sd1, 17'd2), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0001, '0, 4'd0, 32'd100, -32'sd1, 17'd1), 1'b0);
		// full refresh
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd5), 1'b0);
		// since position beyond the modulus
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd100000), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd131071), 1'b0);
		add_row(mk_req(REQ_DELTA, 16'h0000, '0, 4'd0, 32'd100, 32'sd0, 17'd0), 1'b0);
		add_row(mk_req(REQ_CLEAR, 16'h0000, '1, 4'd15, '1, -32'sd1, '1), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd0));
		add_row(mk_req(REQ_GET, 16'h0000, '0, 4'd0, 32'd100, -32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd0));
		add_row(mk_req(REQ_DELTA, 16'hFFFF, '0, 4'd0, 32'd100, -32'sd1, 17'd0), 1'b1,
			mk_rsp(1'b0, '0, 4'd0, 17'd0));
		add_row(mk_req(REQ_PUSH, 16'h0003, 64'h0123_4567_89AB_CDEF, 4'd5, 32'd100, 32'sd0,
			17'd0), 1'b1, mk_rsp(1'b0, '0, 4'd0, 17'd1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (!(src_done && !req_valid && expected_rsp.size() == 0))
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d pushes, %0d gets, %0d delta queries, %0d clears, %0d hits",
			n_push, n_get, n_delta, n_clear, n_hit);
		$display("directed rows then %0d random requests with random idling on both sides",
			rand_issued);
		if (fail_count == 0 && expected_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> group_value_delta_cache_top.f
+incdir+rtl/core
rtl/core/gvdc_pkg.sv
rtl/core/gvdc_ram.sv
rtl/core/gvdc_resolve.sv
rtl/core/group_value_delta_cache_top.sv
tb/testbench.sv
